// File: rtl/core/zsd_pkg.sv
package zsd_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned RowCodeW = 7;
  localparam int unsigned PadCodeW = 8;
  localparam int unsigned BinW     = 10;
  localparam int unsigned LenW     = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FrowW    = 5;
  localparam int unsigned FpadW    = 11;
  localparam int unsigned HitRowW  = 4;
  localparam int unsigned HitPadW  = 10;
  localparam int unsigned TotalW   = 24;

  localparam logic [TotalW-1:0] TotalMax = '1;

  // Pads per readout row code and the row codes per physical row.
  localparam int unsigned PadsPerCode = 160;
  localparam int unsigned CodesPerRow = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SEQ   = 2'd1,
    CMD_ADC   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STATUS_HIT     = 3'd0,
    STATUS_LATE    = 3'd1,
    STATUS_INVALID = 3'd2,
    STATUS_STRAY   = 3'd3,
    STATUS_CLEARED = 3'd4
  } status_e;

  // Physical location of one hit.
  typedef struct packed {
    logic             ok;
    logic [FrowW-1:0] frow;
    logic [FpadW-1:0] fpad;
  } map_t;

endpackage

// File: rtl/core/zsd_count_mem.sv
module zsd_count_mem import zsd_pkg::*; #(
  parameter int unsigned DEPTH = 19200,
  parameter int unsigned AW    = 15
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [ByteW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/zsd_hit_map.sv
module zsd_hit_map import zsd_pkg::*; #(
  parameter int unsigned SECTORS      = 2,
  parameter int unsigned ROWS         = 10,
  parameter int unsigned PADS_PER_ROW = 960
) (
  input  logic                sector_i,
  input  logic [RowCodeW-1:0] row_code_i,
  input  logic [PadCodeW-1:0] pad_code_i,
  output map_t                map_o
);

  logic [RowCodeW-1:0] x;
  logic [12:0]         q_full;
  logic [FrowW-1:0]    q;
  logic [RowCodeW-1:0] rem_full;
  logic [FpadW-1:0]    fpad;

  // Row code minus one divided by six: multiply by 43/256, exact for x < 128.
  always_comb begin
    x        = row_code_i - RowCodeW'(1);
    q_full   = 13'(x) * 13'd43;
    q        = q_full[12:8];
    rem_full = x - RowCodeW'(q) * RowCodeW'(CodesPerRow);
    fpad     = FpadW'(rem_full[2:0]) * FpadW'(PadsPerCode)
             + FpadW'(pad_code_i - PadCodeW'(1));
  end

  always_comb begin
    map_o.frow = q;
    map_o.fpad = fpad;
    map_o.ok   = (row_code_i != '0) && (pad_code_i != '0)
              && (32'(sector_i) < SECTORS)
              && (32'(q) < ROWS) && (32'(fpad) < PADS_PER_ROW);
  end

endmodule

// File: rtl/core/zero_suppressed_sequence_decoder_unit.sv
// Zero-suppressed sequence decoder with per-pad hit counters.
//
// The slave stream carries one beat per command: tuser selects clear, sequence
// word or ADC byte, and tdata holds the sector, the sequence word and the byte.
// Sequence words only update the pad and run registers and give no result.
// Every ADC byte and every clear gives exactly one result beat on the master
// stream, with the status code in tuser.
// The block works on one beat at a time. A sequence word is handled in ST_IDLE alone; a
// stray byte or a late time bin goes to ST_EMIT, an invalid pad through ST_MAP
// to ST_EMIT, and a stored hit through the mapping stage, the address multiply,
// the registered read of the counter memory and its write-back (ST_UPD).
// A clear sweeps the whole counter memory, one entry a cycle, and then gives
// its result beat (SECTORS*ROWS*PADS_PER_ROW entries, 19200 by default).
// After reset the same sweep runs without a result beat, and tready stays low
// until the sweep ends. A result waits in the output register while the
// receiver stalls; the next beat is still accepted and processed until it
// needs the output register itself.
module zero_suppressed_sequence_decoder_unit import zsd_pkg::*; #(
  parameter int unsigned SECTORS      = 2,
  parameter int unsigned ROWS         = 10,
  parameter int unsigned PADS_PER_ROW = 960,
  parameter int unsigned COUNT_MAX    = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: sector [0], seq_word [16:1], adc_value [24:17], zero [31:25]
  input  logic [31:0] s_axis_tdata_i,
  // tuser: cmd [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: hit_sector [0], hit_row [4:1], hit_pad [14:5], time_bin [22:15],
  // sample [30:23], hit_index [38:31], event_total [62:39], zero [63]
  output logic [63:0] m_axis_tdata_o,
  // tuser: status [2:0]
  output logic [2:0]  m_axis_tuser_o
);

  localparam int unsigned DEPTH = SECTORS * ROWS * PADS_PER_ROW;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_ADDR,
    ST_READ,
    ST_UPD,
    ST_EMIT,
    ST_CLEAR
  } state_e;

  state_e state_q;

  // Decoder registers that persist between beats.
  logic [RowCodeW-1:0] row_code_q;
  logic [PadCodeW-1:0] pad_code_q;
  logic [BinW-1:0]     next_bin_q;
  logic [LenW-1:0]     bytes_left_q;
  logic                advance_q;
  logic [TotalW-1:0]   hits_q;

  // The beat in flight.
  logic                it_sec_q;
  logic [RowCodeW-1:0] it_row_q;
  logic [PadCodeW-1:0] it_pad_q;
  logic [ByteW-1:0]    it_bin_q;
  logic [ByteW-1:0]    it_smp_q;
  status_e             pend_status_q;
  map_t                map_q;
  logic [AW-1:0]       addr_q;
  logic [AW-1:0]       clr_addr_q;
  logic                clr_emit_q;

  // Output register.
  logic                out_valid_q;
  status_e             out_status_q;
  logic                out_sec_q;
  logic [HitRowW-1:0]  out_row_q;
  logic [HitPadW-1:0]  out_pad_q;
  logic [ByteW-1:0]    out_bin_q;
  logic [ByteW-1:0]    out_smp_q;
  logic [ByteW-1:0]    out_idx_q;
  logic [TotalW-1:0]   out_total_q;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  cmd_e                in_cmd;
  logic                in_sec;
  logic [15:0]         in_word;
  logic [ByteW-1:0]    in_adc;
  map_t                map_res;
  logic [AW-1:0]       row_lin;
  logic [AW-1:0]       addr_calc;
  logic [ByteW-1:0]    cnt;
  logic [TotalW-1:0]   hits_inc;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [ByteW-1:0]    mem_wr_data;
  logic                mem_rd_en;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  // A result beat enters the output register in this cycle.
  assign out_load        = out_free && ((state_q == ST_UPD) || (state_q == ST_EMIT));

  assign in_cmd  = cmd_e'(s_axis_tuser_i);
  assign in_sec  = s_axis_tdata_i[0];
  assign in_word = s_axis_tdata_i[16:1];
  assign in_adc  = s_axis_tdata_i[24:17];

  zsd_hit_map #(
    .SECTORS      (SECTORS),
    .ROWS         (ROWS),
    .PADS_PER_ROW (PADS_PER_ROW)
  ) u_map (
    .sector_i   (it_sec_q),
    .row_code_i (it_row_q),
    .pad_code_i (it_pad_q),
    .map_o      (map_res)
  );

  // Linear counter address: (sector * ROWS + row) * PADS_PER_ROW + pad.
  always_comb begin
    row_lin   = (it_sec_q ? AW'(ROWS) : '0) + AW'(map_q.frow);
    addr_calc = AW'(row_lin * AW'(PADS_PER_ROW)) + AW'(map_q.fpad);
  end

  assign hits_inc = (hits_q == TotalMax) ? hits_q : hits_q + TotalW'(1);

  // Counter memory port control: the clearing sweep or the hit write-back.
  always_comb begin
    mem_rd_en   = (state_q == ST_READ);
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_q;
    mem_wr_data = cnt + ByteW'(1);
    if (state_q == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_q;
      mem_wr_data = '0;
    end else if (state_q == ST_UPD) begin
      mem_wr_en = out_free && (cnt < ByteW'(COUNT_MAX));
    end
  end

  zsd_count_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      row_code_q    <= '0;
      pad_code_q    <= '0;
      next_bin_q    <= '0;
      bytes_left_q  <= '0;
      advance_q     <= 1'b0;
      hits_q        <= '0;
      it_sec_q      <= 1'b0;
      it_row_q      <= '0;
      it_pad_q      <= '0;
      it_bin_q      <= '0;
      it_smp_q      <= '0;
      pend_status_q <= STATUS_HIT;
      map_q         <= '0;
      addr_q        <= '0;
      clr_addr_q    <= '0;
      clr_emit_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_status_q  <= STATUS_HIT;
      out_sec_q     <= 1'b0;
      out_row_q     <= '0;
      out_pad_q     <= '0;
      out_bin_q     <= '0;
      out_smp_q     <= '0;
      out_idx_q     <= '0;
      out_total_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_cmd)
              CMD_CLEAR: begin
                hits_q       <= '0;
                bytes_left_q <= '0;
                advance_q    <= 1'b0;
                clr_addr_q   <= '0;
                clr_emit_q   <= 1'b1;
                it_bin_q     <= '0;
                it_smp_q     <= '0;
                state_q      <= ST_CLEAR;
              end
              CMD_SEQ: begin
                if (in_word[15]) begin
                  // Pad word: new row and pad, any open run is dropped.
                  row_code_q   <= in_word[14:8];
                  pad_code_q   <= in_word[7:0];
                  bytes_left_q <= '0;
                  advance_q    <= 1'b0;
                end else begin
                  next_bin_q <= {1'b0, in_word[14:6]};
                  if (in_word[4:0] == '0) begin
                    // An empty run only advances the pad when asked to.
                    bytes_left_q <= '0;
                    advance_q    <= 1'b0;
                    if (in_word[5]) begin
                      pad_code_q <= pad_code_q + PadCodeW'(1);
                    end
                  end else begin
                    bytes_left_q <= in_word[4:0];
                    advance_q    <= in_word[5];
                  end
                end
              end
              CMD_ADC: begin
                it_smp_q <= in_adc;
                if (bytes_left_q == '0) begin
                  pend_status_q <= STATUS_STRAY;
                  it_bin_q      <= '0;
                  state_q       <= ST_EMIT;
                end else begin
                  next_bin_q   <= next_bin_q + BinW'(1);
                  it_sec_q     <= in_sec;
                  it_row_q     <= row_code_q;
                  it_pad_q     <= pad_code_q;
                  bytes_left_q <= bytes_left_q - LenW'(1);
                  // The pad advances after the last byte of the run.
                  if ((bytes_left_q == LenW'(1)) && advance_q) begin
                    pad_code_q <= pad_code_q + PadCodeW'(1);
                    advance_q  <= 1'b0;
                  end
                  if (next_bin_q[BinW-1:ByteW] != '0) begin
                    pend_status_q <= STATUS_LATE;
                    it_bin_q      <= '0;
                    state_q       <= ST_EMIT;
                  end else begin
                    it_bin_q <= next_bin_q[ByteW-1:0];
                    state_q  <= ST_MAP;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MAP: begin
          map_q <= map_res;
          if (map_res.ok) begin
            state_q <= ST_ADDR;
          end else begin
            pend_status_q <= STATUS_INVALID;
            state_q       <= ST_EMIT;
          end
        end
        ST_ADDR: begin
          addr_q  <= addr_calc;
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            hits_q       <= hits_inc;
            out_status_q <= STATUS_HIT;
            out_sec_q    <= it_sec_q;
            out_row_q    <= map_q.frow[HitRowW-1:0];
            out_pad_q    <= map_q.fpad[HitPadW-1:0];
            out_bin_q    <= it_bin_q;
            out_smp_q    <= it_smp_q;
            out_idx_q    <= cnt;
            out_total_q  <= hits_inc;
            state_q      <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_status_q <= pend_status_q;
            out_sec_q    <= 1'b0;
            out_row_q    <= '0;
            out_pad_q    <= '0;
            out_bin_q    <= it_bin_q;
            out_smp_q    <= it_smp_q;
            out_idx_q    <= '0;
            out_total_q  <= '0;
            state_q      <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AW'(1);
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            clr_emit_q    <= 1'b0;
            pend_status_q <= STATUS_CLEARED;
            state_q       <= clr_emit_q ? ST_EMIT : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_total_q, out_idx_q, out_smp_q, out_bin_q,
                            out_pad_q, out_row_q, out_sec_q};

`ifndef SYNTHESIS
  // The event total only steps up by one or returns to zero on a clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hits_q != $past(hits_q)) |->
      ((hits_q == $past(hits_q) + TotalW'(1)) || (hits_q == '0)))
    else $error("event hit total jumped");

  // A reported hit always counts itself in the event total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STATUS_HIT)) |-> (out_total_q != '0))
    else $error("hit reported with zero event total");

  // A pending pad advance exists only inside an open run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_left_q == '0) |-> !advance_q)
    else $error("pad advance pending outside a run");

  // A hit write-back to the counter memory happens only in the cycle the hit result enters the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_wr_en && (state_q == ST_UPD)) |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("counter written without a hit result");
`endif

endmodule
